### rtl/mtp_pkg.sv
// mtp_pkg: shared types, constants and the sine table of the melody tone player
// depends on nothing; every rtl file refers to it by scoped names
`default_nettype none

package mtp_pkg;

   // fixed field widths
   localparam int TICK_W  = 16;
   localparam int BEAT_W  = 5;
   localparam int IDX_W   = 6;
   localparam int LEN_W   = 7;
   localparam int DAC_W   = 8;
   localparam int ROM_W   = 5;
   localparam int SINE_LEN = 25;

   // reset values of registers and state
   localparam logic [TICK_W-1:0] TEMPO_RESET  = 16'd45000;
   localparam logic [LEN_W-1:0]  SONG_RESET   = 7'd42;
   localparam logic [DAC_W-1:0]  SAMPLE_RESET = 8'h80;

   // request kinds
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // register indexes of the csr port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMPO = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SONG  = 2'd1;

   // input word
   typedef struct packed {
      logic              req_type;
      logic              button;
      logic              fast_switch;
      logic [IDX_W-1:0]  entry_index;
      logic [TICK_W-1:0] entry_period;
      logic              entry_rest;
      logic [BEAT_W-1:0] entry_beats;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [DAC_W-1:0] dac_value;
      logic             playing;
      logic [IDX_W-1:0] note_number;
   } rsp_word_type;

   // classified word as queued between front and back
   typedef struct packed {
      logic         is_write;
      logic         idx_ok;
      req_word_type word;
   } mtp_cmd_type;

   // one melody entry
   typedef struct packed {
      logic [TICK_W-1:0] period;
      logic              rest;
      logic [BEAT_W-1:0] beats;
   } mtp_entry_type;

   // back end sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_DIV
   } mtp_state_type;

   // one period of the sine wave
   function automatic logic [DAC_W-1:0] sine_at(input logic [ROM_W-1:0] idx);
      logic [DAC_W-1:0] val;
      case (idx)
         5'd0:    val = 8'h80;
         5'd1:    val = 8'h9F;
         5'd2:    val = 8'hBD;
         5'd3:    val = 8'hD7;
         5'd4:    val = 8'hEC;
         5'd5:    val = 8'hF9;
         5'd6:    val = 8'hFF;
         5'd7:    val = 8'hFD;
         5'd8:    val = 8'hF3;
         5'd9:    val = 8'hE2;
         5'd10:   val = 8'hCB;
         5'd11:   val = 8'hAF;
         5'd12:   val = 8'h90;
         5'd13:   val = 8'h6F;
         5'd14:   val = 8'h50;
         5'd15:   val = 8'h32;
         5'd16:   val = 8'h1D;
         5'd17:   val = 8'h0C;
         5'd18:   val = 8'h02;
         5'd19:   val = 8'h00;
         5'd20:   val = 8'h06;
         5'd21:   val = 8'h13;
         5'd22:   val = 8'h28;
         5'd23:   val = 8'h42;
         5'd24:   val = 8'h60;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

### rtl/mtp_front.sv
// mtp_front: accepts request words, classifies them and queues them for the back end
// depends on mtp_pkg
`default_nettype none

module mtp_front #(
   parameter int MAX_NOTES = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire mtp_pkg::req_word_type req_data,
   output      logic                 q_valid,
   input  wire logic                 q_ready,
   output      mtp_pkg::mtp_cmd_type q_cmd
);

   localparam int CMP_W = ($clog2(MAX_NOTES + 1) > mtp_pkg::IDX_W) ?
                          $clog2(MAX_NOTES + 1) : mtp_pkg::IDX_W;

   mtp_pkg::mtp_cmd_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   mtp_pkg::mtp_cmd_type cmd;

   // classify the incoming word
   always_comb begin
      cmd.is_write = (req_data.req_type == mtp_pkg::REQ_WRITE);
      cmd.idx_ok   = (CMP_W'(req_data.entry_index) < CMP_W'(MAX_NOTES));
      cmd.word     = req_data;
   end

   // two-word queue control
   assign req_ready = (count_ff != 2'd2);
   assign q_valid   = (count_ff != 2'd0);
   assign q_cmd     = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = 2'(count_ff + {1'b0, push} - {1'b0, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

`default_nettype wire

### rtl/mtp_div.sv
// mtp_div: restoring divider, one quotient bit per cycle, for the note duration
// depends on mtp_pkg
`default_nettype none

module mtp_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [mtp_pkg::TICK_W-1:0]   dividend,
   input  wire logic [mtp_pkg::BEAT_W-1:0]   divisor,
   output      logic                         done,
   output      logic [mtp_pkg::TICK_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(mtp_pkg::TICK_W);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [mtp_pkg::BEAT_W-1:0] rem_ff, rem_in;
   logic [mtp_pkg::TICK_W-1:0] quo_ff, quo_in;
   logic [mtp_pkg::BEAT_W-1:0] div_ff, div_in;
   logic [mtp_pkg::BEAT_W:0]   trial;

   assign trial = {rem_ff, quo_ff[mtp_pkg::TICK_W-1]};

   // one shift-subtract step
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = mtp_pkg::BEAT_W'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[mtp_pkg::TICK_W-2:0], 1'b1};
         end else begin
            rem_in = trial[mtp_pkg::BEAT_W-1:0];
            quo_in = {quo_ff[mtp_pkg::TICK_W-2:0], 1'b0};
         end
         cnt_in = CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == CNT_W'(mtp_pkg::TICK_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### rtl/mtp_back.sv
// mtp_back: carries out queued words: melody store, button watch, timers, sine output
// depends on mtp_pkg and mtp_div
`default_nettype none

module mtp_back #(
   parameter int MAX_NOTES  = 64,
   parameter int WAVE_STEPS = 25
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [mtp_pkg::TICK_W-1:0]  tempo_ticks,
   input  wire logic [mtp_pkg::LEN_W-1:0]   song_length,
   input  wire logic                        q_valid,
   output      logic                        q_ready,
   input  wire mtp_pkg::mtp_cmd_type        q_cmd,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      mtp_pkg::rsp_word_type       rsp_data
);

   localparam int NOTE_W = $clog2(MAX_NOTES);
   localparam int PH_W   = $clog2(WAVE_STEPS);
   localparam int LEN_W  = ($clog2(MAX_NOTES + 1) > mtp_pkg::LEN_W) ?
                           $clog2(MAX_NOTES + 1) : mtp_pkg::LEN_W;
   localparam int TW     = mtp_pkg::TICK_W;

   // sequencer and play state
   mtp_pkg::mtp_state_type state_ff, state_in;
   logic                   running_ff, running_in;
   logic                   seen_ff, seen_in;
   logic                   fast_ff, fast_in;
   logic [NOTE_W-1:0]      note_pos_ff, note_pos_in;
   logic [PH_W-1:0]        phase_ff, phase_in;
   logic [mtp_pkg::ROM_W-1:0] rom_idx_ff, rom_idx_in;
   logic [TW-1:0]          tone_ff, tone_in;
   logic [TW-1:0]          dur_ff, dur_in;
   logic [TW-1:0]          lim_ff, lim_in;
   logic [mtp_pkg::DAC_W-1:0] sample_ff, sample_in;
   logic [TW-1:0]          period_ff, period_in;
   logic                   rest_ff, rest_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   mtp_pkg::rsp_word_type  rsp_ff;

   // melody store
   mtp_pkg::mtp_entry_type mem [MAX_NOTES];
   mtp_pkg::mtp_entry_type rd_ff;
   mtp_pkg::mtp_entry_type wr_entry;
   logic                   mem_we;

   // decode of the word at the head of the queue
   logic              take, is_tick, btn;
   logic              start_play, stop_play, advance, note_end, start_load, emit;
   logic [LEN_W-1:0]  eff_len, song_ext, nxt_pos;
   logic              div_start, div_done;
   logic [TW-1:0]     quotient;
   logic [mtp_pkg::BEAT_W-1:0] divisor;

   assign btn        = q_cmd.word.button;
   assign is_tick    = !q_cmd.is_write;
   assign take       = (state_ff == mtp_pkg::ST_IDLE) && q_valid && !rsp_valid_ff;
   assign q_ready    = take;
   assign start_play = take && is_tick && !running_ff && !btn && seen_ff;
   assign stop_play  = take && is_tick && running_ff && !btn && seen_ff;
   assign advance    = take && is_tick && running_ff && !stop_play;
   assign note_end   = advance && (dur_ff == lim_ff);
   assign start_load = start_play || note_end;
   assign emit       = (take && !start_load) ||
                       ((state_ff == mtp_pkg::ST_DIV) && div_done);
   assign mem_we     = take && q_cmd.is_write && !running_ff && q_cmd.idx_ok;

   // song length clamped to one..MAX_NOTES, next position wraps at it
   always_comb begin
      song_ext = LEN_W'(song_length);
      if (song_ext == '0) begin
         eff_len = LEN_W'(1);
      end else if (song_ext > LEN_W'(MAX_NOTES)) begin
         eff_len = LEN_W'(MAX_NOTES);
      end else begin
         eff_len = song_ext;
      end
      nxt_pos = LEN_W'(LEN_W'(note_pos_ff) + 1'b1);
      if (nxt_pos >= eff_len) begin
         nxt_pos = '0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mtp_pkg::ST_IDLE: begin
            if (start_load) begin
               state_in = mtp_pkg::ST_READ;
            end
         end
         mtp_pkg::ST_READ: state_in = mtp_pkg::ST_LOAD;
         mtp_pkg::ST_LOAD: state_in = mtp_pkg::ST_DIV;
         mtp_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = mtp_pkg::ST_IDLE;
            end
         end
         default: state_in = mtp_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      running_in = running_ff;
      seen_in    = seen_ff;
      fast_in    = fast_ff;
      note_pos_in = note_pos_ff;
      phase_in   = phase_ff;
      rom_idx_in = rom_idx_ff;
      tone_in    = tone_ff;
      dur_in     = dur_ff;
      lim_in     = lim_ff;
      sample_in  = sample_ff;
      period_in  = period_ff;
      rest_in    = rest_ff;
      div_start  = 1'b0;
      divisor    = (rd_ff.beats == '0) ? mtp_pkg::BEAT_W'(1) : rd_ff.beats;

      case (state_ff)
         mtp_pkg::ST_IDLE: begin
            if (take && is_tick) begin
               if (btn) begin
                  seen_in = 1'b1;
               end
               if (start_play) begin
                  seen_in     = 1'b0;
                  running_in  = 1'b1;
                  fast_in     = !q_cmd.word.fast_switch;
                  note_pos_in = '0;
               end else if (stop_play) begin
                  seen_in     = 1'b0;
                  running_in  = 1'b0;
                  note_pos_in = '0;
               end else if (note_end) begin
                  note_pos_in = NOTE_W'(nxt_pos);
               end else if (advance) begin
                  dur_in = TW'(dur_ff + 1'b1);
                  if (tone_ff == period_ff) begin
                     tone_in   = '0;
                     sample_in = mtp_pkg::sine_at(rom_idx_ff);
                     if (!rest_ff) begin
                        if (phase_ff == PH_W'(WAVE_STEPS - 1)) begin
                           phase_in   = '0;
                           rom_idx_in = '0;
                        end else begin
                           phase_in   = PH_W'(phase_ff + 1'b1);
                           rom_idx_in = (rom_idx_ff == mtp_pkg::ROM_W'(mtp_pkg::SINE_LEN - 1)) ?
                                        '0 : mtp_pkg::ROM_W'(rom_idx_ff + 1'b1);
                        end
                     end
                  end else begin
                     tone_in = TW'(tone_ff + 1'b1);
                  end
               end
            end
         end
         mtp_pkg::ST_LOAD: begin
            period_in = rd_ff.period;
            rest_in   = rd_ff.rest;
            tone_in   = '0;
            dur_in    = '0;
            div_start = 1'b1;
         end
         mtp_pkg::ST_DIV: begin
            if (div_done) begin
               lim_in = fast_ff ? {1'b0, quotient[TW-1:1]} : quotient;
            end
         end
         default: begin
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // duration divider
   mtp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (tempo_ticks),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mtp_pkg::ST_IDLE;
         running_ff   <= 1'b0;
         seen_ff      <= 1'b0;
         fast_ff      <= 1'b0;
         note_pos_ff  <= '0;
         phase_ff     <= '0;
         rom_idx_ff   <= '0;
         tone_ff      <= '0;
         dur_ff       <= '0;
         lim_ff       <= '0;
         sample_ff    <= mtp_pkg::SAMPLE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         seen_ff      <= seen_in;
         fast_ff      <= fast_in;
         note_pos_ff  <= note_pos_in;
         phase_ff     <= phase_in;
         rom_idx_ff   <= rom_idx_in;
         tone_ff      <= tone_in;
         dur_ff       <= dur_in;
         lim_ff       <= lim_in;
         sample_ff    <= sample_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // current note and result word
   always_ff @(posedge clock) begin
      period_ff <= period_in;
      rest_ff   <= rest_in;
      if (emit) begin
         rsp_ff.dac_value   <= sample_in;
         rsp_ff.playing     <= running_in;
         rsp_ff.note_number <= mtp_pkg::IDX_W'(note_pos_in);
      end
   end

   // melody store, one write and one registered read port
   assign wr_entry.period = q_cmd.word.entry_period;
   assign wr_entry.rest   = q_cmd.word.entry_rest;
   assign wr_entry.beats  = q_cmd.word.entry_beats;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[NOTE_W'(q_cmd.word.entry_index)] <= wr_entry;
      end
      rd_ff <= mem[note_pos_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### rtl/melody_tone_player.sv
// melody_tone_player: top level, csr registers and the front and back ends
// depends on mtp_pkg, mtp_front, mtp_back
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | req_data  (mtp_pkg::req_word_type)
//   rsp     | out       | rsp_valid / rsp_ready | rsp_data  (mtp_pkg::rsp_word_type)
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// a word goes through a two-word queue, then the back end, which registers its result;
// the back end takes no new word while a result is still held
// a word that starts a note goes through the store read, the load, then the 16-bit
// divider at one quotient bit a cycle
// the queue takes up to two words while a result waits on rsp_ready
// reset is synchronous; the melody store is not cleared, csr writes are always ready
`default_nettype none

module melody_tone_player #(
   parameter int MAX_NOTES  = 64,
   parameter int WAVE_STEPS = 25
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire mtp_pkg::req_word_type            req_data,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output      mtp_pkg::rsp_word_type            rsp_data,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [mtp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mtp_pkg::TICK_W-1:0]       csr_wdata
);

   logic [mtp_pkg::TICK_W-1:0] tempo_ff, tempo_in;
   logic [mtp_pkg::LEN_W-1:0]  song_ff, song_in;
   logic                       q_valid, q_ready;
   mtp_pkg::mtp_cmd_type       q_cmd;

   // csr write decode
   assign csr_ready = 1'b1;

   always_comb begin
      tempo_in = tempo_ff;
      song_in  = song_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            mtp_pkg::CSR_TEMPO: tempo_in = csr_wdata;
            mtp_pkg::CSR_SONG:  song_in  = csr_wdata[mtp_pkg::LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tempo_ff <= mtp_pkg::TEMPO_RESET;
         song_ff  <= mtp_pkg::SONG_RESET;
      end else begin
         tempo_ff <= tempo_in;
         song_ff  <= song_in;
      end
   end

   // front end with queue
   mtp_front #(
      .MAX_NOTES (MAX_NOTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_cmd     (q_cmd)
   );

   // back end
   mtp_back #(
      .MAX_NOTES  (MAX_NOTES),
      .WAVE_STEPS (WAVE_STEPS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .tempo_ticks (tempo_ff),
      .song_length (song_ff),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_cmd       (q_cmd),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

### tb/sv/melody_tone_player_tb.sv
`timescale 1ns / 100ps
// melody_tone_player_tb: self-checking bench for the melody tone player
// depends on mtp_pkg and melody_tone_player; keeps a shadow of the player state
// and checks every result word against it

module melody_tone_player_tb;

   localparam int SONG_SLOTS    = 64;
   localparam int PHASE_STEPS   = 25;
   localparam int PHASE_COUNT   = 12;
   localparam int PHASE_WORDS   = 80;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int HOLD_AFTER    = 200;
   localparam int HOLD_CYCLES   = 300;

   // one sine period, first sample in the top byte
   localparam logic [8*PHASE_STEPS-1:0] SINE_BYTES = {
      8'h80, 8'h9F, 8'hBD, 8'hD7, 8'hEC, 8'hF9, 8'hFF, 8'hFD, 8'hF3, 8'hE2,
      8'hCB, 8'hAF, 8'h90, 8'h6F, 8'h50, 8'h32, 8'h1D, 8'h0C, 8'h02, 8'h00,
      8'h06, 8'h13, 8'h28, 8'h42, 8'h60
   };

   // shadow of the player: registers, timers, melody and the words still due
   class tone_shadow;
      logic [mtp_pkg::TICK_W-1:0] tempo_ticks;
      logic [mtp_pkg::LEN_W-1:0]  song_length;
      bit                         running;
      bit                         button_seen_high;
      bit                         fast_mode;
      logic [mtp_pkg::IDX_W-1:0]  note_pos;
      logic [mtp_pkg::ROM_W-1:0]  wave_phase;
      logic [mtp_pkg::TICK_W-1:0] tone_count;
      logic [mtp_pkg::TICK_W-1:0] duration_count;
      logic [mtp_pkg::TICK_W-1:0] duration_limit;
      logic [mtp_pkg::DAC_W-1:0]  sample_out;
      mtp_pkg::mtp_entry_type     melody [SONG_SLOTS];
      mtp_pkg::rsp_word_type      dac_words_due [$];
      int                         mismatches;

      function new();
         tempo_ticks      = mtp_pkg::TEMPO_RESET;
         song_length      = mtp_pkg::SONG_RESET;
         running          = 1'b0;
         button_seen_high = 1'b0;
         fast_mode        = 1'b0;
         note_pos         = '0;
         wave_phase       = '0;
         tone_count       = '0;
         duration_count   = '0;
         duration_limit   = '0;
         sample_out       = mtp_pkg::SAMPLE_RESET;
         mismatches       = 0;
         foreach (melody[i]) melody[i] = '0;
      endfunction

      function void set_register(input logic [mtp_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [mtp_pkg::TICK_W-1:0] value);
         if (idx == mtp_pkg::CSR_TEMPO) begin
            tempo_ticks = value;
         end else if (idx == mtp_pkg::CSR_SONG) begin
            song_length = value[mtp_pkg::LEN_W-1:0];
         end
      endfunction

      function int words_due();
         return dac_words_due.size();
      endfunction

      // song length clamped to 1..SONG_SLOTS
      function int song_span();
         int n;
         n = song_length;
         if (n == 0) n = 1;
         if (n > SONG_SLOTS) n = SONG_SLOTS;
         return n;
      endfunction

      // load a note: duration from tempo and beats, both timers restart
      function void start_note(input int pos);
         int beats;
         int ticks;
         if (pos >= SONG_SLOTS) pos = 0;
         note_pos = mtp_pkg::IDX_W'(pos);
         beats = melody[pos].beats;
         if (beats == 0) beats = 1;
         ticks = tempo_ticks;
         ticks = ticks / beats;
         if (fast_mode) ticks = ticks / 2;
         duration_limit = mtp_pkg::TICK_W'(ticks);
         duration_count = '0;
         tone_count     = '0;
      endfunction

      // one tick of play: note change or else duration and tone timers
      function void advance_timers();
         int next_pos;
         int ph;
         if (duration_count == duration_limit) begin
            next_pos = note_pos + 1;
            if (next_pos >= song_span()) next_pos = 0;
            start_note(next_pos);
            return;
         end
         duration_count = duration_count + 1'b1;
         if (tone_count == melody[note_pos].period) begin
            tone_count = '0;
            ph = wave_phase % PHASE_STEPS;
            sample_out = SINE_BYTES[8*(PHASE_STEPS-1-ph) +: 8];
            if (!melody[note_pos].rest)
               wave_phase = mtp_pkg::ROM_W'((wave_phase + 1) % PHASE_STEPS);
         end else begin
            tone_count = tone_count + 1'b1;
         end
      endfunction

      // accepted input word: update the shadow and queue the word it yields
      function void take_request(input mtp_pkg::req_word_type w);
         mtp_pkg::rsp_word_type due;
         if (w.req_type == mtp_pkg::REQ_WRITE) begin
            if (!running) begin
               melody[w.entry_index].period = w.entry_period;
               melody[w.entry_index].rest   = w.entry_rest;
               melody[w.entry_index].beats  = w.entry_beats;
            end
         end else if (!running) begin
            if (w.button) begin
               button_seen_high = 1'b1;
            end else if (button_seen_high) begin
               button_seen_high = 1'b0;
               running   = 1'b1;
               fast_mode = !w.fast_switch;
               start_note(0);
            end
         end else begin
            if (w.button) begin
               button_seen_high = 1'b1;
               advance_timers();
            end else if (button_seen_high) begin
               button_seen_high = 1'b0;
               running  = 1'b0;
               note_pos = '0;
            end else begin
               advance_timers();
            end
         end
         due.dac_value   = sample_out;
         due.playing     = running;
         due.note_number = note_pos;
         dac_words_due.push_back(due);
      endfunction

      // accepted result word against the oldest one due
      function void check_dac_word(input mtp_pkg::rsp_word_type got);
         mtp_pkg::rsp_word_type want;
         if (dac_words_due.size() == 0) begin
            $display("%0t: result word %h arrived with none due", $time, got);
            mismatches++;
            return;
         end
         want = dac_words_due.pop_front();
         if (got.dac_value !== want.dac_value) begin
            $display("%0t: dac_value expected %h, got %h", $time, want.dac_value,
                     got.dac_value);
            mismatches++;
         end
         if (got.playing !== want.playing) begin
            $display("%0t: playing expected %b, got %b", $time, want.playing, got.playing);
            mismatches++;
         end
         if (got.note_number !== want.note_number) begin
            $display("%0t: note_number expected %0d, got %0d", $time, want.note_number,
                     got.note_number);
            mismatches++;
         end
      endfunction
   endclass

   logic                              clock     = 1'b0;
   logic                              reset     = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   mtp_pkg::req_word_type             req_data  = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   mtp_pkg::rsp_word_type             rsp_data;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [mtp_pkg::CSR_IDX_W-1:0]     csr_index = mtp_pkg::CSR_TEMPO;
   logic [mtp_pkg::TICK_W-1:0]        csr_wdata = '0;

   tone_shadow shadow = new();
   bit         steady_sender = 1'b0;

   melody_tone_player u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // tick word; the entry fields are ignored but still toggled
   function automatic mtp_pkg::req_word_type tick_word(input logic button,
                                                       input logic fast_switch);
      mtp_pkg::req_word_type w;
      w.req_type     = mtp_pkg::REQ_TICK;
      w.button       = button;
      w.fast_switch  = fast_switch;
      w.entry_index  = mtp_pkg::IDX_W'($urandom_range(0, SONG_SLOTS - 1));
      w.entry_period = mtp_pkg::TICK_W'($urandom_range(0, 65535));
      w.entry_rest   = 1'($urandom_range(0, 1));
      w.entry_beats  = mtp_pkg::BEAT_W'($urandom_range(0, 31));
      return w;
   endfunction

   function automatic mtp_pkg::req_word_type entry_word(input int idx, input int period,
                                                        input bit rest, input int beats);
      mtp_pkg::req_word_type w;
      w.req_type     = mtp_pkg::REQ_WRITE;
      w.button       = 1'($urandom_range(0, 1));
      w.fast_switch  = 1'($urandom_range(0, 1));
      w.entry_index  = mtp_pkg::IDX_W'(idx);
      w.entry_period = mtp_pkg::TICK_W'(period);
      w.entry_rest   = rest;
      w.entry_beats  = mtp_pkg::BEAT_W'(beats);
      return w;
   endfunction

   // melody entry with mostly short tone periods
   function automatic mtp_pkg::req_word_type random_entry(input int idx);
      int pick;
      int period;
      pick = $urandom_range(0, 9);
      if (pick < 5) period = $urandom_range(0, 3);
      else if (pick < 8) period = $urandom_range(4, 20);
      else period = $urandom_range(0, 65535);
      return entry_word(idx, period, $urandom_range(0, 3) == 0, $urandom_range(0, 31));
   endfunction

   // next word: mostly well-formed start, play and stop sequences
   function automatic mtp_pkg::req_word_type next_random_word(input int stop_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (!shadow.running) begin
         if (shadow.button_seen_high) return tick_word(roll >= 65, 1'($urandom_range(0, 1)));
         if (roll < 20) return random_entry($urandom_range(0, SONG_SLOTS - 1));
         return tick_word(roll >= 30, 1'($urandom_range(0, 1)));
      end
      if (roll < 3) return random_entry($urandom_range(0, SONG_SLOTS - 1));
      if (shadow.button_seen_high) return tick_word(roll >= 73, 1'($urandom_range(0, 1)));
      return tick_word(roll < 3 + stop_pct, 1'($urandom_range(0, 1)));
   endfunction

   // offer one input word and wait for its handshake
   task automatic offer_word(input mtp_pkg::req_word_type w);
      int gap;
      gap = steady_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      shadow.take_request(w);
   endtask

   task automatic write_register(input logic [mtp_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [mtp_pkg::TICK_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      shadow.set_register(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering, wait for every due word, then let a note division finish
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (shadow.words_due() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side: random stalls, one long hold while the sender keeps offering
   initial begin : rsp_side
      int stall_left;
      int seen;
      bit held;
      bit steady;
      stall_left = 0;
      seen       = 0;
      held       = 1'b0;
      steady     = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            shadow.check_dac_word(rsp_data);
            seen++;
            if (seen % 150 == 0) steady = !steady;
            stall_left = steady ? 0 : pick_gap();
         end
         if (!held && seen >= HOLD_AFTER && req_valid) begin
            held       = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   initial begin : req_side
      logic [mtp_pkg::TICK_W-1:0] tempo;
      logic [mtp_pkg::TICK_W-1:0] song;
      int                         stop_pct;
      tempo    = '0;
      song     = '0;
      stop_pct = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // short notes and a five-entry song for the opening checks
      write_register(mtp_pkg::CSR_TEMPO, 16'd6);
      write_register(mtp_pkg::CSR_SONG, 16'd5);

      // every entry written before any can be played
      for (int i = 0; i < SONG_SLOTS; i++) offer_word(random_entry(i));

      // zero beats counts as one, tone step every tick
      offer_word(entry_word(0, 0, 1'b0, 0));
      // rest note with beats beyond sixteen
      offer_word(entry_word(1, 1, 1'b1, 31));
      offer_word(entry_word(2, 16'hFFFF, 1'b0, 16));
      offer_word(entry_word(SONG_SLOTS - 1, 2, 1'b0, 1));
      // low level alone does not start, a release does
      offer_word(tick_word(1'b0, 1'b1));
      offer_word(tick_word(1'b1, 1'b1));
      offer_word(tick_word(1'b1, 1'b0));
      offer_word(tick_word(1'b0, 1'b1));
      // play through the first note changes
      repeat (9) offer_word(tick_word(1'b0, 1'b0));
      // melody write while playing is dropped
      offer_word(entry_word(0, 16'hFFFF, 1'b1, 31));
      // stop, then restart in fast mode with fresh timers
      offer_word(tick_word(1'b1, 1'b0));
      offer_word(tick_word(1'b0, 1'b0));
      offer_word(tick_word(1'b1, 1'b0));
      offer_word(tick_word(1'b0, 1'b0));
      repeat (3) offer_word(tick_word(1'b0, 1'b1));

      // random phases, each under its own tempo and song length
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_and_settle();
         case (phase)
            0: begin
               tempo = 16'd1;  song = 16'd1;   stop_pct = 2;
            end
            1: begin
               // long run through many notes so the next phase shrinks the song under it
               tempo = 16'd3;  song = 16'd64;  stop_pct = 0;
            end
            2: begin
               tempo = 16'd20; song = 16'd0;   stop_pct = 2;
            end
            3: begin
               tempo = 16'hFFFF; song = 16'd127; stop_pct = 3;
            end
            default: begin
               stop_pct = $urandom_range(0, 4);
               song     = mtp_pkg::TICK_W'($urandom_range(0, 127));
               case ($urandom_range(0, 19)) inside
                  [0:2]:   tempo = mtp_pkg::TICK_W'($urandom_range(1, 65535));
                  [3:6]:   tempo = mtp_pkg::TICK_W'($urandom_range(41, 400));
                  default: tempo = mtp_pkg::TICK_W'($urandom_range(1, 40));
               endcase
            end
         endcase
         write_register(mtp_pkg::CSR_TEMPO, tempo);
         write_register(mtp_pkg::CSR_SONG, song);
         steady_sender = (phase % 4 == 3);
         repeat (PHASE_WORDS) offer_word(next_random_word(stop_pct));
      end
      drain_and_settle();

      if (shadow.mismatches == 0 && shadow.words_due() == 0) begin
         $display("No mismatches found");
      end else begin
         if (shadow.words_due() != 0)
            $display("%0t: %0d result words never arrived", $time, shadow.words_due());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
